// ===== sv/tpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tpq_pkg : shared types and constants of the priority queue server
// Request and response beats, operation codes and controller/datapath links.
// ----------------------------------------------------------------------------
package tpq_pkg;

   localparam int NUM_QUEUES = 3;

   typedef logic [1:0] op_type;
   typedef logic [1:0] qidx_type;

   localparam op_type OP_ENQUEUE = 2'd0;
   localparam op_type OP_SERVE   = 2'd1;
   localparam op_type OP_CLEAR   = 2'd2;

   localparam qidx_type Q_HIGH   = 2'd0;
   localparam qidx_type Q_MEDIUM = 2'd1;
   localparam qidx_type Q_LOW    = 2'd2;

   localparam logic [7:0] PRIO_HIGH   = 8'd1;
   localparam logic [7:0] PRIO_MEDIUM = 8'd2;

   typedef struct packed {
      op_type      op;
      logic [15:0] record_tag;
      logic [7:0]  priority_value;
   } req_type;

   typedef struct packed {
      logic        dropped;
      logic        served_valid;
      logic [15:0] served_tag;
      logic [7:0]  served_priority;
      logic [6:0]  high_count;
      logic [6:0]  medium_count;
      logic [6:0]  low_count;
      logic [15:0] total_served;
      logic        last_valid;
      logic [15:0] last_tag;
      logic [7:0]  last_priority;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic enqueue;
      logic fetch;
      logic serve;
      logic clear;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   any_ready;
   } dp_status_type;

endpackage

// ===== sv/tpq_ram.sv =====
// ----------------------------------------------------------------------------
// tpq_ram : generic single-clock RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpq_ctrl : sequencing controller of the priority queue server
// Steps each request through execute, optional store fetch and response.
// ----------------------------------------------------------------------------
module tpq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  tpq_pkg::dp_status_type status,
   output logic                  busy,
   output logic                  rsp_valid,
   output tpq_pkg::ctrl_cmd_type cmd
);
   import tpq_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_FETCH = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // a new beat may be taken while the previous response is on the ports
   assign busy      = (state_ff == S_EXEC) || (state_ff == S_FETCH);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.capture = start && !busy;
      unique case (state_ff)
         S_IDLE, S_RESP: begin
            state_in = cmd.capture ? S_EXEC : S_IDLE;
         end
         S_EXEC: begin
            state_in = S_RESP;
            unique case (status.op)
               OP_ENQUEUE: cmd.enqueue = 1'b1;
               OP_SERVE: begin
                  if (status.any_ready) begin
                     cmd.fetch = 1'b1;
                     state_in  = S_FETCH;
                  end
               end
               OP_CLEAR: cmd.clear = 1'b1;
               default: ;
            endcase
         end
         S_FETCH: begin
            cmd.serve = 1'b1;
            state_in  = S_RESP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/tpq_datapath.sv =====
// ----------------------------------------------------------------------------
// tpq_datapath : queue pointers, record store and served history
// Three circular queues share one RAM; history keeps last record and count.
// ----------------------------------------------------------------------------
module tpq_datapath #(
   parameter int QUEUE_DEPTH = 64,
   parameter int TAG_BITS    = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tpq_pkg::req_type       req_item,
   input  tpq_pkg::ctrl_cmd_type  cmd,
   output tpq_pkg::dp_status_type status,
   output tpq_pkg::rsp_type       rsp_item
);
   import tpq_pkg::*;

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int TAGS_BITS  = (TAG_BITS < 16) ? TAG_BITS : 16;
   localparam int ENTRY_BITS = TAGS_BITS + 8;
   localparam int RAM_DEPTH  = NUM_QUEUES * QUEUE_DEPTH;
   localparam int ADDR_BITS  = $clog2(RAM_DEPTH);

   req_type               req_ff;
   logic [PTR_BITS-1:0]   head_ff  [NUM_QUEUES];
   logic [PTR_BITS-1:0]   tail_ff  [NUM_QUEUES];
   logic [CNT_BITS-1:0]   count_ff [NUM_QUEUES];
   logic [PTR_BITS-1:0]   head_in  [NUM_QUEUES];
   logic [PTR_BITS-1:0]   tail_in  [NUM_QUEUES];
   logic [CNT_BITS-1:0]   count_in [NUM_QUEUES];
   qidx_type              srv_q_ff;
   logic [COUNT_BITS-1:0] total_ff;
   logic                  last_valid_ff;
   logic [TAGS_BITS-1:0]  last_tag_ff;
   logic [7:0]            last_prio_ff;
   logic                  dropped_ff;
   logic                  served_valid_ff;
   logic [TAGS_BITS-1:0]  served_tag_ff;
   logic [7:0]            served_prio_ff;

   qidx_type              enq_q;
   qidx_type              srv_q;
   qidx_type              addr_q;
   logic [PTR_BITS-1:0]   addr_ptr;
   logic [ADDR_BITS-1:0]  ram_addr;
   logic                  enq_full;
   logic                  enq_ok;
   logic [ENTRY_BITS-1:0] wr_entry;
   logic [ENTRY_BITS-1:0] rd_entry;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] ptr);
      return (ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   // route by raw priority
   always_comb begin
      priority if (req_ff.priority_value == PRIO_HIGH) begin
         enq_q = Q_HIGH;
      end else if (req_ff.priority_value == PRIO_MEDIUM) begin
         enq_q = Q_MEDIUM;
      end else begin
         enq_q = Q_LOW;
      end
   end

   // highest non-empty queue wins
   always_comb begin
      priority if (count_ff[Q_HIGH] != '0) begin
         srv_q = Q_HIGH;
      end else if (count_ff[Q_MEDIUM] != '0) begin
         srv_q = Q_MEDIUM;
      end else begin
         srv_q = Q_LOW;
      end
   end

   assign status.op        = req_ff.op;
   assign status.any_ready = (count_ff[Q_HIGH] != '0) || (count_ff[Q_MEDIUM] != '0)
                             || (count_ff[Q_LOW] != '0);

   assign enq_full = (count_ff[enq_q] == CNT_BITS'(QUEUE_DEPTH));
   assign enq_ok   = cmd.enqueue && !enq_full;

   assign addr_q   = cmd.enqueue ? enq_q : srv_q;
   assign addr_ptr = cmd.enqueue ? tail_ff[enq_q] : head_ff[srv_q];
   assign ram_addr = ADDR_BITS'(addr_q) * ADDR_BITS'(QUEUE_DEPTH) + ADDR_BITS'(addr_ptr);
   assign wr_entry = {req_ff.record_tag[TAGS_BITS-1:0], req_ff.priority_value};

   tpq_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (enq_ok),
      .wr_addr (ram_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.fetch),
      .rd_addr (ram_addr),
      .rd_data (rd_entry)
   );

   always_comb begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
         head_in[q]  = head_ff[q];
         tail_in[q]  = tail_ff[q];
         count_in[q] = count_ff[q];
         if (enq_ok && (enq_q == qidx_type'(q))) begin
            tail_in[q]  = next_ptr(tail_ff[q]);
            count_in[q] = count_ff[q] + 1'b1;
         end
         if (cmd.serve && (srv_q_ff == qidx_type'(q))) begin
            head_in[q]  = next_ptr(head_ff[q]);
            count_in[q] = count_ff[q] - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < NUM_QUEUES; q++) begin
            head_ff[q]  <= '0;
            tail_ff[q]  <= '0;
            count_ff[q] <= '0;
         end
         total_ff        <= '0;
         last_valid_ff   <= 1'b0;
         last_tag_ff     <= '0;
         last_prio_ff    <= '0;
         dropped_ff      <= 1'b0;
         served_valid_ff <= 1'b0;
         served_tag_ff   <= '0;
         served_prio_ff  <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (cmd.capture) begin
            dropped_ff      <= 1'b0;
            served_valid_ff <= 1'b0;
            served_tag_ff   <= '0;
            served_prio_ff  <= '0;
         end
         if (cmd.enqueue) begin
            dropped_ff <= enq_full;
         end
         if (cmd.serve) begin
            served_valid_ff <= 1'b1;
            served_tag_ff   <= rd_entry[ENTRY_BITS-1:8];
            served_prio_ff  <= rd_entry[7:0];
            last_valid_ff   <= 1'b1;
            last_tag_ff     <= rd_entry[ENTRY_BITS-1:8];
            last_prio_ff    <= rd_entry[7:0];
            // hold at all ones
            if (total_ff != '1) begin
               total_ff <= total_ff + 1'b1;
            end
         end
         if (cmd.clear) begin
            total_ff      <= '0;
            last_valid_ff <= 1'b0;
            last_tag_ff   <= '0;
            last_prio_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
      if (cmd.fetch) begin
         srv_q_ff <= srv_q;
      end
   end

   always_comb begin
      rsp_item.dropped         = dropped_ff;
      rsp_item.served_valid    = served_valid_ff;
      rsp_item.served_tag      = 16'(served_tag_ff);
      rsp_item.served_priority = served_prio_ff;
      rsp_item.high_count      = 7'(count_ff[Q_HIGH]);
      rsp_item.medium_count    = 7'(count_ff[Q_MEDIUM]);
      rsp_item.low_count       = 7'(count_ff[Q_LOW]);
      rsp_item.total_served    = 16'(total_ff);
      rsp_item.last_valid      = last_valid_ff;
      rsp_item.last_tag        = 16'(last_tag_ff);
      rsp_item.last_priority   = last_prio_ff;
   end

endmodule

// ===== sv/three_level_priority_queue_server_unit.sv =====
// ----------------------------------------------------------------------------
// three_level_priority_queue_server_unit : strict-priority three-queue server
// Enqueue, serve and clear-history requests over three FIFO queues.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a request beat on req_item; it is taken at an edge where
//   busy is low. Exactly one response beat follows on rsp_item, marked by
//   rsp_valid for a single cycle; the receiver must take it then.
//   Enqueue, clear and serve-when-empty requests go from the execute state
//   to the response state; a serve that removes a record passes through a
//   fetch state between them, for the registered read of the record store.
//   busy drops during the response cycle, so a new request can be taken
//   while the response is shown.
//   Reset empties all queues, zeroes the served count and clears the last
//   served record; store contents are not cleared, as only written entries
//   are ever read. Responses cannot be stalled.
// ----------------------------------------------------------------------------
module three_level_priority_queue_server_unit #(
   parameter int QUEUE_DEPTH = 64,
   parameter int TAG_BITS    = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tpq_pkg::req_type req_item,
   output logic             rsp_valid,
   output tpq_pkg::rsp_type rsp_item
);
   import tpq_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   tpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   tpq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_BITS    (TAG_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule

// ===== sv/tpq_checker.sv =====
// ----------------------------------------------------------------------------
// tpq_checker : port-level checks of the priority queue server
// Bound to the top level; watches request and response beats.
// ----------------------------------------------------------------------------
module tpq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input tpq_pkg::rsp_type rsp_item
);
   import tpq_pkg::*;

   // busy is raised in the cycle after a beat is accepted
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accepted request");

   a_no_adjacent_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response beats in adjacent cycles");

   a_drop_not_served: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.dropped |-> !rsp_item.served_valid)
      else $error("response both dropped and served");

   a_served_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.served_valid |->
         rsp_item.last_valid && (rsp_item.last_tag == rsp_item.served_tag)
         && (rsp_item.last_priority == rsp_item.served_priority))
      else $error("served record not reported as last served");

   a_no_last_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last_valid |->
         (rsp_item.last_tag == '0) && (rsp_item.last_priority == '0))
      else $error("last record fields non-zero without a last record");

endmodule

bind three_level_priority_queue_server_unit tpq_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

// ===== verif/tpq_checker.sv =====
// ----------------------------------------------------------------------------
// tpq_scoreboard : response predictor and scoreboard of the priority queue server
// Follows every accepted request beat with its own copy of the three queues and
// the served history, and compares each response beat with the oldest
// predicted one, field by field.
// ----------------------------------------------------------------------------
module tpq_scoreboard #(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  tpq_pkg::req_type req_item,
   input  logic             rsp_valid,
   input  tpq_pkg::rsp_type rsp_item,
   output int               fail_count,
   output int               pending_count
);
   import tpq_pkg::*;

   localparam logic [15:0] SERVED_MAX = '1;

   logic [15:0] slot_tag  [NUM_QUEUES][DEPTH];
   logic [7:0]  slot_prio [NUM_QUEUES][DEPTH];
   int unsigned head [NUM_QUEUES];
   int unsigned tail [NUM_QUEUES];
   int unsigned fill [NUM_QUEUES];
   logic [15:0] served_cnt;
   logic        last_ok;
   logic [15:0] last_tag_q;
   logic [7:0]  last_prio_q;

   rsp_type     expected_rsp [$];

   initial fail_count = 0;
   initial pending_count = 0;

   function automatic rsp_type predict_response(input req_type r);
      rsp_type  res;
      qidx_type q;
      logic     found;
      res   = '0;
      found = 1'b0;
      case (r.op)
         OP_ENQUEUE: begin
            q = (r.priority_value == PRIO_HIGH)   ? Q_HIGH :
                (r.priority_value == PRIO_MEDIUM) ? Q_MEDIUM : Q_LOW;
            if (fill[q] >= DEPTH) begin
               res.dropped = 1'b1;
            end else begin
               slot_tag[q][tail[q]]  = r.record_tag;
               slot_prio[q][tail[q]] = r.priority_value;
               tail[q] = (tail[q] + 1) % DEPTH;
               fill[q]++;
            end
         end
         OP_SERVE: begin
            // take the head of the highest level that holds anything
            for (int k = 0; k < NUM_QUEUES; k++) begin
               if (!found && fill[k] != 0) begin
                  found       = 1'b1;
                  last_ok     = 1'b1;
                  last_tag_q  = slot_tag[k][head[k]];
                  last_prio_q = slot_prio[k][head[k]];
                  head[k] = (head[k] + 1) % DEPTH;
                  fill[k]--;
                  if (served_cnt != SERVED_MAX) served_cnt++;
                  res.served_valid    = 1'b1;
                  res.served_tag      = last_tag_q;
                  res.served_priority = last_prio_q;
               end
            end
         end
         OP_CLEAR: begin
            served_cnt  = '0;
            last_ok     = 1'b0;
            last_tag_q  = '0;
            last_prio_q = '0;
         end
         default: ;
      endcase
      res.high_count    = 7'(fill[Q_HIGH]);
      res.medium_count  = 7'(fill[Q_MEDIUM]);
      res.low_count     = 7'(fill[Q_LOW]);
      res.total_served  = served_cnt;
      res.last_valid    = last_ok;
      res.last_tag      = last_ok ? last_tag_q : '0;
      res.last_priority = last_ok ? last_prio_q : '0;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int k = 0; k < NUM_QUEUES; k++) begin
            head[k] = 0;
            tail[k] = 0;
            fill[k] = 0;
         end
         served_cnt  = '0;
         last_ok     = 1'b0;
         last_tag_q  = '0;
         last_prio_q = '0;
         expected_rsp.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("response beat with nothing outstanding");
            end else begin
               want = expected_rsp.pop_front();
               check_field("dropped", 16'(rsp_item.dropped), 16'(want.dropped));
               check_field("served_valid", 16'(rsp_item.served_valid),
                           16'(want.served_valid));
               check_field("served_tag", rsp_item.served_tag, want.served_tag);
               check_field("served_priority", 16'(rsp_item.served_priority),
                           16'(want.served_priority));
               check_field("high_count", 16'(rsp_item.high_count),
                           16'(want.high_count));
               check_field("medium_count", 16'(rsp_item.medium_count),
                           16'(want.medium_count));
               check_field("low_count", 16'(rsp_item.low_count),
                           16'(want.low_count));
               check_field("total_served", rsp_item.total_served, want.total_served);
               check_field("last_valid", 16'(rsp_item.last_valid),
                           16'(want.last_valid));
               check_field("last_tag", rsp_item.last_tag, want.last_tag);
               check_field("last_priority", 16'(rsp_item.last_priority),
                           16'(want.last_priority));
            end
         end
         if (start && !busy) expected_rsp.push_back(predict_response(req_item));
      end
      pending_count <= expected_rsp.size();
   end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb : top level of the priority queue server testbench
// Drives a short directed sequence and then random enqueue, serve and clear
// traffic in fill, drain and mixed stretches, under three idling phases; the
// scoreboard beside the block scores every response beat.
// ----------------------------------------------------------------------------
module tb;
   import tpq_pkg::*;

   localparam op_type OP_NOP      = 2'd3;
   localparam int     RAND_ITEMS  = 1450;
   localparam int     BLOCK_LEN   = 120;
   localparam int     STALL_LIMIT = 4000;

   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;
   int      fail_count;
   int      pending_count;
   int      idle_cycles = 0;

   three_level_priority_queue_server_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   tpq_scoreboard u_scoreboard (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_item      (rsp_item),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   function automatic req_type make_req(input op_type op, input logic [15:0] tag,
                                        input logic [7:0] prio);
      req_type r;
      r.op             = op;
      r.record_tag     = tag;
      r.priority_value = prio;
      return r;
   endfunction

   // priority aimed at one level; anything but 1 and 2 lands in the low queue
   function automatic logic [7:0] prio_for_level(input int level);
      logic [7:0] v;
      case (level)
         0:       v = PRIO_HIGH;
         1:       v = PRIO_MEDIUM;
         default: v = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255, 3));
      endcase
      return v;
   endfunction

   function automatic req_type draw_request(input int mode, input int favoured);
      int         pick;
      op_type     op;
      logic [7:0] prio;
      pick = $urandom_range(99);
      case (mode)
         MODE_FILL:  op = (pick < 92) ? OP_ENQUEUE : (pick < 98) ? OP_SERVE : OP_NOP;
         MODE_DRAIN: op = (pick < 80) ? OP_SERVE : (pick < 95) ? OP_ENQUEUE : OP_CLEAR;
         default:    op = (pick < 45) ? OP_ENQUEUE : (pick < 85) ? OP_SERVE :
                          (pick < 95) ? OP_CLEAR : OP_NOP;
      endcase
      pick = $urandom_range(99);
      if (mode == MODE_FILL && pick < 80) prio = prio_for_level(favoured);
      else if (pick < 90)                prio = prio_for_level($urandom_range(2));
      else                               prio = 8'($urandom_range(255));
      return make_req(op, 16'($urandom_range(65535)), prio);
   endfunction

   // hold the beat until an edge with busy low takes it
   task automatic issue(input req_type r);
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_cycle;
      start <= 1'b0;
      @(posedge clock);
   endtask

   // hold off until every outstanding response has come back
   task automatic drain;
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin
      int idle_pct;
      int phase;
      int favoured;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty server, then records at every level and strict-order service
      issue(make_req(OP_SERVE,   16'h0000, 8'h00));
      issue(make_req(OP_CLEAR,   16'hFFFF, 8'hFF));
      issue(make_req(OP_NOP,     16'h0000, 8'h00));
      issue(make_req(OP_ENQUEUE, 16'h0000, 8'h00));
      issue(make_req(OP_ENQUEUE, 16'hFFFF, 8'hFF));
      issue(make_req(OP_ENQUEUE, 16'h1234, PRIO_MEDIUM));
      issue(make_req(OP_ENQUEUE, 16'hA5A5, PRIO_HIGH));
      issue(make_req(OP_ENQUEUE, 16'h5A5A, 8'h03));
      issue(make_req(OP_NOP,     16'hFFFF, 8'hFF));
      issue(make_req(OP_SERVE,   16'h0000, 8'h00));
      issue(make_req(OP_SERVE,   16'hFFFF, 8'hFF));
      issue(make_req(OP_SERVE,   16'h0000, 8'h00));
      issue(make_req(OP_CLEAR,   16'h0000, 8'h00));
      issue(make_req(OP_SERVE,   16'h0000, 8'h00));
      issue(make_req(OP_ENQUEUE, 16'hFFFF, PRIO_HIGH));
      issue(make_req(OP_SERVE,   16'h0000, 8'h00));
      issue(make_req(OP_SERVE,   16'h0000, 8'h00));
      issue(make_req(OP_SERVE,   16'h0000, 8'h00));
      issue(make_req(OP_NOP,     16'h0000, 8'h00));
      issue(make_req(OP_CLEAR,   16'h0000, 8'h00));

      phase    = -1;
      favoured = 0;
      idle_pct = 0;
      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i * 3 / RAND_ITEMS != phase) begin
            phase = i * 3 / RAND_ITEMS;
            idle_pct = (phase == 0) ? 0 : (phase == 1) ? 88 : 8;
            drain();
         end
         if (i % BLOCK_LEN == 0) favoured = $urandom_range(2);
         while ($urandom_range(99) < idle_pct) idle_cycle();
         issue(draw_request((i / BLOCK_LEN) % 3, favoured));
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== three_level_priority_queue_server_unit.f =====
sv/tpq_pkg.sv
sv/tpq_ram.sv
sv/tpq_ctrl.sv
sv/tpq_datapath.sv
sv/three_level_priority_queue_server_unit.sv
sv/tpq_checker.sv
verif/tpq_checker.sv
verif/tb.sv
